// ----- src/asw_pkg.sv -----
// shared types and constants for the padded box slab intersection pipeline
// no dependencies
package asw_pkg;

  localparam int NRM_W = 2;

  localparam logic [NRM_W-1:0] NRM_ZERO = 2'b00;
  localparam logic [NRM_W-1:0] NRM_POS  = 2'b01;
  localparam logic [NRM_W-1:0] NRM_NEG  = 2'b11;

  // per axis flags from the front stage
  typedef struct packed {
    logic unb;     // zero delta, start inside slab
    logic miss;    // zero delta, start outside slab
    logic dneg;    // delta negative
    logic qneg_n;  // near quotient negative
    logic qneg_f;  // far quotient negative
  } asw_axis_t;

  // decision handed from the selection stage
  typedef struct packed {
    logic             hit;
    logic [NRM_W-1:0] nrm_x;
    logic [NRM_W-1:0] nrm_y;
  } asw_sel_t;

endpackage

// ----- src/asw_slab_prep.sv -----
// front stage for one axis: doubled numerators, divisor magnitude, flags
// depends on asw_pkg
module asw_slab_prep #(
  parameter int CB = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [CB-1:0]         c_i,
  input  logic [CB-1:0]         s_i,
  input  logic [CB-2:0]         size_i,
  input  logic [CB-2:0]         pad_i,
  input  logic [CB-1:0]         d_i,
  output logic [CB+1:0]         near_mag_o,
  output logic [CB+1:0]         far_mag_o,
  output logic [CB:0]           den_o,
  output asw_pkg::asw_axis_t    flags_o
);
  import asw_pkg::*;

  logic signed [CB:0]   diff;
  logic signed [CB+1:0] rel2;
  logic [CB:0]          span;
  logic signed [CB+2:0] rel_s;
  logic signed [CB+2:0] spn_s;
  logic signed [CB+2:0] nnear;
  logic signed [CB+2:0] nfar;
  logic [CB+2:0]        nnear_abs;
  logic [CB+2:0]        nfar_abs;
  logic [CB+1:0]        rel_abs;
  logic [CB-1:0]        dmag;
  logic                 dneg;
  logic                 dzero;
  logic                 in_slab;
  asw_axis_t            flags_nxt;

  always_comb begin
    diff      = $signed({c_i[CB-1], c_i}) - $signed({s_i[CB-1], s_i});
    rel2      = {diff, 1'b0};
    span      = {2'b00, size_i} + {1'b0, pad_i, 1'b0};
    rel_s     = $signed({rel2[CB+1], rel2});
    spn_s     = $signed({2'b00, span});
    dneg      = d_i[CB-1];
    dzero     = (d_i == '0);
    nnear     = dneg ? (rel_s + spn_s) : (rel_s - spn_s);
    nfar      = dneg ? (rel_s - spn_s) : (rel_s + spn_s);
    nnear_abs = nnear[CB+2] ? (-nnear) : nnear;
    nfar_abs  = nfar[CB+2] ? (-nfar) : nfar;
    rel_abs   = rel2[CB+1] ? (-rel2) : rel2;
    in_slab   = (rel_abs[CB:0] <= span);
    dmag      = dneg ? (-d_i) : d_i;
    flags_nxt.unb    = dzero & in_slab;
    flags_nxt.miss   = dzero & ~in_slab;
    flags_nxt.dneg   = dneg;
    flags_nxt.qneg_n = nnear[CB+2] ^ dneg;
    flags_nxt.qneg_f = nfar[CB+2] ^ dneg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_mag_o <= nnear_abs[CB+1:0];
      far_mag_o  <= nfar_abs[CB+1:0];
      den_o      <= {dmag, 1'b0};
      flags_o    <= flags_nxt;
    end
  end

endmodule

// ----- src/asw_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// no dependencies
module asw_div #(
  parameter int DW = 50,
  parameter int VW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quot_o
);

  logic [DW-1:0] shf_r [0:DW-1];
  logic [VW-1:0] rem_r [0:DW-2];
  logic [VW-1:0] dvs_r [0:DW-2];

  genvar k;
  generate
    for (k = 0; k < DW; k++) begin : g_stage
      logic [VW-1:0] rem_in;
      logic [DW-1:0] shf_in;
      logic [VW-1:0] dvs_in;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          ge;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign shf_in = dividend_i;
        assign dvs_in = divisor_i;
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign shf_in = shf_r[k-1];
        assign dvs_in = dvs_r[k-1];
      end
      assign trial = {rem_in, shf_in[DW-1]};
      assign diff  = trial - {1'b0, dvs_in};
      assign ge    = (trial >= {1'b0, dvs_in});
      always_ff @(posedge clk) begin
        if (en) begin
          shf_r[k] <= {shf_in[DW-2:0], ge};
        end
      end
      if (k < DW-1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
            dvs_r[k] <= dvs_in;
          end
        end
      end
    end
  endgenerate

  assign quot_o = shf_r[DW-1];

endmodule

// ----- src/asw_delay.sv -----
// side data delay line matching the divider latency
// no dependencies
module asw_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         v_i,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  output logic [W-1:0] d_o
);

  logic [W-1:0]     data_r [0:DEPTH-1];
  logic [DEPTH-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], v_i};
    end
  end

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clk) begin
        if (en) begin
          data_r[k] <= (k == 0) ? d_i : data_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  assign v_o = v_r[DEPTH-1];
  assign d_o = data_r[DEPTH-1];

endmodule

// ----- src/asw_hit_sel.sv -----
// signed entry and exit times, overlap test, time clamp and normal choice
// depends on asw_pkg
module asw_hit_sel #(
  parameter int DW = 50,
  parameter int FB = 16,
  parameter int PW = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  logic [DW-1:0]         qnx_i,
  input  logic [DW-1:0]         qfx_i,
  input  logic [DW-1:0]         qny_i,
  input  logic [DW-1:0]         qfy_i,
  input  asw_pkg::asw_axis_t    fx_i,
  input  asw_pkg::asw_axis_t    fy_i,
  input  logic [PW-1:0]         pay_i,
  output logic                  v_o,
  output asw_pkg::asw_sel_t     sel_o,
  output logic [FB:0]           t_o,
  output logic [PW-1:0]         pay_o
);
  import asw_pkg::*;

  localparam int TW = DW + 1;
  localparam logic signed [TW-1:0] T_ONE = {{(TW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [TW-1:0] T_ZERO = '0;
  localparam logic signed [TW-1:0] BIG   = {2'b01, {(TW-2){1'b0}}};
  localparam logic signed [TW-1:0] NBIG  = {2'b11, {(TW-2){1'b0}}};

  logic signed [TW-1:0] nx_r, fx_r, ny_r, fy_r;
  logic                 miss_r, dnx_r, dny_r, v1_r;
  logic [PW-1:0]        pay1_r;

  function automatic logic signed [TW-1:0] stime(input logic [DW-1:0] q, input logic neg);
    logic signed [TW-1:0] qs;
    qs = $signed({1'b0, q});
    return neg ? -qs : qs;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= fx_i.unb ? NBIG : stime(qnx_i, fx_i.qneg_n);
      fx_r   <= fx_i.unb ? BIG  : stime(qfx_i, fx_i.qneg_f);
      ny_r   <= fy_i.unb ? NBIG : stime(qny_i, fy_i.qneg_n);
      fy_r   <= fy_i.unb ? BIG  : stime(qfy_i, fy_i.qneg_f);
      miss_r <= fx_i.miss | fy_i.miss;
      dnx_r  <= fx_i.dneg;
      dny_r  <= fy_i.dneg;
      pay1_r <= pay_i;
    end
  end

  logic                 xgt;
  logic signed [TW-1:0] tn;
  logic                 hit;
  asw_sel_t             sel_nxt;
  logic [FB:0]          t_nxt;

  always_comb begin
    xgt = (nx_r > ny_r);
    tn  = xgt ? nx_r : ny_r;
    hit = ~miss_r & ~(nx_r > fy_r) & ~(ny_r > fx_r)
        & ~(nx_r >= T_ONE) & ~(ny_r >= T_ONE)
        & ~(fx_r <= T_ZERO) & ~(fy_r <= T_ZERO);
    sel_nxt.hit   = hit;
    sel_nxt.nrm_x = NRM_ZERO;
    sel_nxt.nrm_y = NRM_ZERO;
    t_nxt         = '0;
    if (hit) begin
      t_nxt = tn[TW-1] ? '0 : tn[FB:0];
      if (xgt) begin
        sel_nxt.nrm_x = dnx_r ? NRM_POS : NRM_NEG;
      end else begin
        sel_nxt.nrm_y = dny_r ? NRM_POS : NRM_NEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_o <= sel_nxt;
      t_o   <= t_nxt;
      pay_o <= pay1_r;
    end
  end

endmodule

// ----- src/asw_output.sv -----
// remaining motion and contact point for one axis, scaled by time and saturated
// no dependencies
module asw_output #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic          hit_i,
  input  logic [FB:0]   t_i,
  input  logic [CB-1:0] d_i,
  input  logic [CB-1:0] s_i,
  output logic [CB-1:0] remain_o,
  output logic [CB-1:0] contact_o
);

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [CB+1:0] MAXV = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [CB+1:0] MINV = {3'b111, {(CB-1){1'b0}}};

  logic [CB-1:0]    dmag;
  logic [FB:0]      trem;
  logic [CB+FB:0]   prem_r, pcon_r;
  logic             dneg_r, hit_r;
  logic [CB-1:0]    s_r;

  assign dmag = d_i[CB-1] ? (-d_i) : d_i;
  assign trem = ONE - t_i;

  always_ff @(posedge clk) begin
    if (en) begin
      prem_r <= {{(FB+1){1'b0}}, dmag} * {{CB{1'b0}}, trem};
      pcon_r <= {{(FB+1){1'b0}}, dmag} * {{CB{1'b0}}, t_i};
      dneg_r <= d_i[CB-1];
      hit_r  <= hit_i;
      s_r    <= s_i;
    end
  end

  function automatic logic [CB-1:0] sat(input logic signed [CB+1:0] v);
    if (v > MAXV) return MAXV[CB-1:0];
    if (v < MINV) return MINV[CB-1:0];
    return v[CB-1:0];
  endfunction

  logic signed [CB+1:0] rm, cm, rv, cv;

  always_comb begin
    rm = $signed({1'b0, prem_r[CB+FB:FB]});
    cm = $signed({1'b0, pcon_r[CB+FB:FB]});
    rv = dneg_r ? rm : -rm;
    cv = $signed({{2{s_r[CB-1]}}, s_r}) + (dneg_r ? -cm : cm);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remain_o  <= hit_r ? sat(rv) : '0;
      contact_o <= hit_r ? sat(cv) : '0;
    end
  end

endmodule

// ----- src/aabb_segment_sweep_hit.sv -----
// top level: segment against padded box slab test, fully pipelined
// depends on asw_pkg, asw_slab_prep, asw_div, asw_delay, asw_hit_sel, asw_output
//
// channel  | direction | handshake              | contents
// in_      | request   | in_tvalid / in_tready  | box, start, motion, padding
// out_     | result    | out_tvalid / out_tready| hit flag, time, normal, remain, contact
//
// one request per cycle while the result side is not stalled
// the bit-per-stage dividers for the four slab times make up most of the pipeline
// reset clears only the valid bits of every stage
// a stalled result holds the whole pipeline; nothing is dropped or repeated
module aabb_segment_sweep_hit #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // box_center_x, box_center_y, box_width, box_height, start_x, start_y,
  // move_x, move_y, pad_x, pad_y
  input  logic [((10*COORD_BITS-4+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit
  output logic out_tuser,
  // hit_time, normal_x, normal_y, remain_x, remain_y, contact_x, contact_y
  output logic [((FRAC_BITS+5+4*COORD_BITS+7)/8)*8-1:0] out_tdata
);
  import asw_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int NW  = CB + 2;
  localparam int DW  = NW + FB;
  localparam int VW  = CB + 1;
  localparam int AW  = $bits(asw_axis_t);
  localparam int PW  = 4 * CB;
  localparam int SW  = 2 * AW + PW;
  localparam int OW  = ((FB + 5 + 4 * CB + 7) / 8) * 8;
  localparam int OFS_CY = CB;
  localparam int OFS_W  = 2 * CB;
  localparam int OFS_H  = 3 * CB - 1;
  localparam int OFS_SX = 4 * CB - 2;
  localparam int OFS_SY = 5 * CB - 2;
  localparam int OFS_MX = 6 * CB - 2;
  localparam int OFS_MY = 7 * CB - 2;
  localparam int OFS_PX = 8 * CB - 2;
  localparam int OFS_PY = 9 * CB - 3;

  logic adv;
  assign adv       = ~out_tvalid | out_tready;
  assign in_tready = adv;

  logic [CB-1:0] cx, cy, sx, sy, mx, my;
  logic [CB-2:0] bw, bh, px, py;
  assign cx = in_tdata[CB-1:0];
  assign cy = in_tdata[OFS_CY +: CB];
  assign bw = in_tdata[OFS_W  +: CB-1];
  assign bh = in_tdata[OFS_H  +: CB-1];
  assign sx = in_tdata[OFS_SX +: CB];
  assign sy = in_tdata[OFS_SY +: CB];
  assign mx = in_tdata[OFS_MX +: CB];
  assign my = in_tdata[OFS_MY +: CB];
  assign px = in_tdata[OFS_PX +: CB-1];
  assign py = in_tdata[OFS_PY +: CB-1];

  logic          v_prep_r;
  logic [NW-1:0] nmx, fmx, nmy, fmy;
  logic [VW-1:0] denx, deny;
  asw_axis_t     flx, fly;
  logic [CB-1:0] sx_r, sy_r, mx_r, my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_prep_r <= 1'b0;
    end else if (adv) begin
      v_prep_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= sx;
      sy_r <= sy;
      mx_r <= mx;
      my_r <= my;
    end
  end

  asw_slab_prep #(.CB(CB)) u_prep_x (
    .clk(clk), .en(adv), .c_i(cx), .s_i(sx), .size_i(bw), .pad_i(px), .d_i(mx),
    .near_mag_o(nmx), .far_mag_o(fmx), .den_o(denx), .flags_o(flx)
  );

  asw_slab_prep #(.CB(CB)) u_prep_y (
    .clk(clk), .en(adv), .c_i(cy), .s_i(sy), .size_i(bh), .pad_i(py), .d_i(my),
    .near_mag_o(nmy), .far_mag_o(fmy), .den_o(deny), .flags_o(fly)
  );

  logic [DW-1:0] qnx, qfx, qny, qfy;

  asw_div #(.DW(DW), .VW(VW)) u_div_nx (
    .clk(clk), .en(adv), .dividend_i({nmx, {FB{1'b0}}}), .divisor_i(denx), .quot_o(qnx)
  );
  asw_div #(.DW(DW), .VW(VW)) u_div_fx (
    .clk(clk), .en(adv), .dividend_i({fmx, {FB{1'b0}}}), .divisor_i(denx), .quot_o(qfx)
  );
  asw_div #(.DW(DW), .VW(VW)) u_div_ny (
    .clk(clk), .en(adv), .dividend_i({nmy, {FB{1'b0}}}), .divisor_i(deny), .quot_o(qny)
  );
  asw_div #(.DW(DW), .VW(VW)) u_div_fy (
    .clk(clk), .en(adv), .dividend_i({fmy, {FB{1'b0}}}), .divisor_i(deny), .quot_o(qfy)
  );

  logic          v_dly;
  logic [SW-1:0] side_dly;

  asw_delay #(.W(SW), .DEPTH(DW)) u_side (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_i(v_prep_r),
    .d_i({fly, flx, sy_r, sx_r, my_r, mx_r}),
    .v_o(v_dly), .d_o(side_dly)
  );

  logic          v_sel;
  asw_sel_t      sel;
  logic [FB:0]   tval;
  logic [PW-1:0] pay;

  asw_hit_sel #(.DW(DW), .FB(FB), .PW(PW)) u_sel (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_i(v_dly),
    .qnx_i(qnx), .qfx_i(qfx), .qny_i(qny), .qfy_i(qfy),
    .fx_i(asw_axis_t'(side_dly[PW +: AW])), .fy_i(asw_axis_t'(side_dly[PW+AW +: AW])),
    .pay_i(side_dly[PW-1:0]),
    .v_o(v_sel), .sel_o(sel), .t_o(tval), .pay_o(pay)
  );

  logic [CB-1:0] rem_x, rem_y, con_x, con_y;

  asw_output #(.CB(CB), .FB(FB)) u_out_x (
    .clk(clk), .en(adv), .hit_i(sel.hit), .t_i(tval),
    .d_i(pay[CB-1:0]), .s_i(pay[2*CB +: CB]),
    .remain_o(rem_x), .contact_o(con_x)
  );

  asw_output #(.CB(CB), .FB(FB)) u_out_y (
    .clk(clk), .en(adv), .hit_i(sel.hit), .t_i(tval),
    .d_i(pay[CB +: CB]), .s_i(pay[3*CB +: CB]),
    .remain_o(rem_y), .contact_o(con_y)
  );

  logic        v_o1_r, v_o2_r;
  asw_sel_t    sel1_r, sel2_r;
  logic [FB:0] t1_r, t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o1_r <= 1'b0;
      v_o2_r <= 1'b0;
    end else if (adv) begin
      v_o1_r <= v_sel;
      v_o2_r <= v_o1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel1_r <= sel;
      sel2_r <= sel1_r;
      t1_r   <= tval;
      t2_r   <= t1_r;
    end
  end

  assign out_tvalid = v_o2_r;
  assign out_tuser  = sel2_r.hit;
  assign out_tdata  = OW'({con_y, con_x, rem_y, rem_x, sel2_r.nrm_y, sel2_r.nrm_x, t2_r});

  // checks on the result stream
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries non-zero fields");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[FB:0] <= {1'b1, {FB{1'b0}}})
    else $error("hit time above one");

  a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((sel2_r.nrm_x == NRM_ZERO) != (sel2_r.nrm_y == NRM_ZERO)))
    else $error("hit without exactly one normal axis");

endmodule

// ----- test/aabb_hit_checker.sv -----
// result checker for the padded box slab intersection block: watches both
// channels, predicts each result from the accepted request and compares
// depends on asw_pkg
`timescale 1ns / 1ps

module aabb_hit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         out_tuser,
  input  logic [151:0] out_tdata,
  output int           errors,
  output int           pending,
  output int           requests,
  output int           hits
);
  import asw_pkg::*;

  localparam longint T_ONE = 64'sd65536;
  localparam longint T_INF = 64'sd1 <<< 62;
  localparam longint C_MAX = 64'sd2147483647;
  localparam longint C_MIN = -64'sd2147483648;

  typedef struct packed {
    logic             hit;
    logic [16:0]      t;
    logic [NRM_W-1:0] nx;
    logic [NRM_W-1:0] ny;
    logic [31:0]      rx;
    logic [31:0]      ry;
    logic [31:0]      px;
    logic [31:0]      py;
  } sweep_res_t;

  sweep_res_t expected_hits[$];

  function automatic longint unsigned amag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint time_quot(longint num, longint den);
    longint unsigned q;
    q = (amag(num) << 16) / amag(den);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint time_scale(longint a, longint t);
    longint unsigned p;
    p = (amag(a) * longint'(t)) >> 16;
    return a < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  function automatic bit axis_times(longint c, longint s, longint size, longint pad,
                                    longint d, output longint tn, output longint tf,
                                    output longint sg);
    longint span, rel2;
    span = size + 2 * pad;
    rel2 = 2 * (c - s);
    tn = 0;
    tf = 0;
    sg = 1;
    if (d == 0) begin
      if (amag(rel2) <= span) begin
        tn = -T_INF;
        tf = T_INF;
        return 1;
      end
      return 0;
    end
    sg = d > 0 ? 1 : -1;
    tn = time_quot(rel2 - sg * span, 2 * d);
    tf = time_quot(rel2 + sg * span, 2 * d);
    return 1;
  endfunction

  function automatic logic [NRM_W-1:0] face(longint sg);
    return sg > 0 ? NRM_NEG : NRM_POS;
  endfunction

  function automatic sweep_res_t predict_hit(logic [319:0] d);
    longint cx, cy, w, h, sx, sy, dx, dy, px, py;
    longint nx, fx, gx, ny, fy, gy, tn, tf, t, rem;
    sweep_res_t r;
    cx = longint'($signed(d[31:0]));
    cy = longint'($signed(d[63:32]));
    w  = longint'(d[94:64]);
    h  = longint'(d[125:95]);
    sx = longint'($signed(d[157:126]));
    sy = longint'($signed(d[189:158]));
    dx = longint'($signed(d[221:190]));
    dy = longint'($signed(d[253:222]));
    px = longint'(d[284:254]);
    py = longint'(d[315:285]);
    r = '0;
    if (!axis_times(cx, sx, w, px, dx, nx, fx, gx)) return r;
    if (!axis_times(cy, sy, h, py, dy, ny, fy, gy)) return r;
    if (nx > fy || ny > fx) return r;
    tn = nx > ny ? nx : ny;
    tf = fx < fy ? fx : fy;
    if (tn >= T_ONE || tf <= 0) return r;
    t = tn < 0 ? 0 : tn;
    rem = T_ONE - t;
    r.hit = 1'b1;
    r.t   = t[16:0];
    r.nx  = nx > ny ? face(gx) : NRM_ZERO;
    r.ny  = nx > ny ? NRM_ZERO : face(gy);
    r.rx  = 32'(clamp_coord(time_scale(-dx, rem)));
    r.ry  = 32'(clamp_coord(time_scale(-dy, rem)));
    r.px  = 32'(clamp_coord(sx + time_scale(dx, t)));
    r.py  = 32'(clamp_coord(sy + time_scale(dy, t)));
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    sweep_res_t e;
    if (!rst_n) begin
      errors   = 0;
      requests = 0;
      hits     = 0;
      expected_hits.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_hits = {expected_hits, predict_hit(in_tdata)};
        requests++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got %b %h", $time, out_tuser, out_tdata);
        end else begin
          e = expected_hits.pop_front();
          if (e.hit) hits++;
          check_field("hit", 32'(e.hit), 32'(out_tuser));
          check_field("hit_time", 32'(e.t), 32'(out_tdata[16:0]));
          check_field("normal_x", 32'(e.nx), 32'(out_tdata[18:17]));
          check_field("normal_y", 32'(e.ny), 32'(out_tdata[20:19]));
          check_field("remain_x", e.rx, out_tdata[52:21]);
          check_field("remain_y", e.ry, out_tdata[84:53]);
          check_field("contact_x", e.px, out_tdata[116:85]);
          check_field("contact_y", e.py, out_tdata[148:117]);
          check_field("pad", 32'd0, 32'(out_tdata[151:149]));
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top for aabb_segment_sweep_hit: drives directed and random requests
// with random gaps and stalls, gives the verdict from aabb_hit_checker
// depends on asw_pkg, aabb_segment_sweep_hit, aabb_hit_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM = 500;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [30:0] UMAX = 31'h7fff_ffff;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         out_tuser;
  logic [151:0] out_tdata;
  int           errors, pending, requests, hits;
  int           sent;
  bit           busy_idle;

  aabb_segment_sweep_hit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  aabb_hit_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .errors    (errors),
    .pending   (pending),
    .requests  (requests),
    .hits      (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_box(logic [31:0] cx, logic [31:0] cy, logic [30:0] w, logic [30:0] h,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] dx,
                          logic [31:0] dy, logic [30:0] px, logic [30:0] py);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, py, px, dy, dx, sy, sx, h, w, cy, cx};
    do @(posedge clk); while (!in_tready);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMAX;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int mode;
    logic [31:0] cx, cy, sx, sy, dx, dy;
    logic [30:0] w, h, px, py;
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      cx = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      cy = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      w  = $urandom_range(0, 32'h003f_ffff);
      h  = $urandom_range(0, 32'h003f_ffff);
      px = $urandom_range(0, 3) == 0 ? 31'd0 : $urandom_range(0, 32'h000f_ffff);
      py = $urandom_range(0, 3) == 0 ? 31'd0 : $urandom_range(0, 32'h000f_ffff);
      sx = cx + $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      sy = cy + $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      dx = (cx - sx) * $urandom_range(1, 3) + $signed($urandom_range(0, 32'h3_ffff))
           - 32'sh2_0000;
      dy = (cy - sy) * $urandom_range(1, 3) + $signed($urandom_range(0, 32'h3_ffff))
           - 32'sh2_0000;
      if ($urandom_range(0, 9) == 0) dx = 32'd0;
      if ($urandom_range(0, 9) == 0) dy = 32'd0;
    end else if (mode < 85) begin
      cx = $urandom; cy = $urandom; sx = $urandom; sy = $urandom;
      dx = $urandom; dy = $urandom;
      w = $urandom; h = $urandom; px = $urandom; py = $urandom;
    end else begin
      cx = pick_edge(); cy = pick_edge(); sx = pick_edge(); sy = pick_edge();
      dx = pick_edge(); dy = pick_edge();
      w = pick_edge(); h = pick_edge(); px = pick_edge(); py = pick_edge();
    end
    send_box(cx, cy, w, h, sx, sy, dx, dy, px, py);
  endtask

  // result side: random stalls, one long hold-off once the pipe is busy
  initial begin
    int g;
    bit held;
    out_tready = 1'b0;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && sent >= 60) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    sent      = 0;
    busy_idle = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // both deltas zero, start inside, then outside
    send_box(0, 0, q16(4), q16(4), q16(1), q16(-1), 0, 0, 0, 0);
    send_box(0, 0, q16(4), q16(4), q16(5), 0, 0, 0, 0, 0);
    // zero delta on boundary of padded slab
    send_box(0, 0, q16(4), q16(4), q16(3), q16(-10), 0, q16(20), q16(1), q16(1));
    // approach from each side
    send_box(0, 0, q16(2), q16(2), q16(-10), 0, q16(20), 0, 0, 0);
    send_box(0, 0, q16(2), q16(2), q16(10), 0, q16(-20), 0, 0, 0);
    send_box(0, 0, q16(2), q16(2), 0, q16(-10), 0, q16(20), 0, 0);
    send_box(0, 0, q16(2), q16(2), 0, q16(10), 0, q16(-20), 0, 0);
    // corner tie
    send_box(0, 0, q16(2), q16(2), q16(-5), q16(-5), q16(10), q16(10), 0, 0);
    // start inside and moving, leaving on the boundary, entry after 1
    send_box(0, 0, q16(4), q16(4), q16(1), q16(1), q16(3), q16(1), q16(1), 0);
    send_box(0, 0, q16(2), q16(2), q16(1), 0, q16(5), 0, 0, 0);
    send_box(0, 0, q16(2), q16(2), q16(-10), 0, q16(5), 0, 0, 0);
    send_box(0, 0, q16(2), q16(2), q16(-10), 0, q16(9), 0, 0, 0);
    // exit time truncating to zero
    send_box(0, 0, q16(2), q16(2), 32'h0000_ffff, 0, CMAX, 0, 0, 0);
    // extremes
    send_box(CMIN, CMIN, UMAX, UMAX, CMAX, CMAX, CMIN, CMIN, UMAX, UMAX);
    send_box(CMAX, CMAX, UMAX, UMAX, CMIN, CMIN, CMAX, CMAX, UMAX, UMAX);
    send_box(CMAX, CMIN, 0, 0, CMIN, CMAX, CMAX, CMIN, 0, 0);
    send_box(0, 0, UMAX, UMAX, CMIN, CMAX, CMAX, CMIN, UMAX, UMAX);
    send_box(CMIN, CMAX, 0, UMAX, CMIN, CMAX, 0, 0, 0, UMAX);
    send_box(32'hffff_ffff, 1, 1, 1, 1, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 1);
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) busy_idle = ($urandom_range(0, 2) == 0);
      send_random();
    end
    in_tvalid <= 1'b0;
    while (pending != 0 || requests != sent) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run covered %0d requests: %0d hits, %0d misses, with gaps and stalls",
             requests, hits, requests - hits);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
